// File: hdl/mi3_pkg.sv
// ----------------------------------------------------------------------------
// mi3_pkg
// Shared widths and request/result types for the 3x3 fixed-point inverse.
// ----------------------------------------------------------------------------
package mi3_pkg;

  localparam int ELEM_W        = 16;
  localparam int FRAC_BITS_DEF = 8;
  // cofactor: difference of two ELEM_W x ELEM_W products
  localparam int COF_W         = 2 * ELEM_W + 1;
  // determinant: sum of three ELEM_W x COF_W products
  localparam int DET_W         = 3 * ELEM_W + 3;
  // quotient bits resolved by the divider before clamping
  localparam int QB            = ELEM_W + 1;
  localparam int COF_LAT       = 4;
  localparam int DIV_LAT       = QB + 3;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [COF_W-1:0]  cof_t;
  typedef logic signed [DET_W-1:0]  det_t;

  typedef struct packed {
    elem_t in_r0c0;
    elem_t in_r0c1;
    elem_t in_r0c2;
    elem_t in_r1c0;
    elem_t in_r1c1;
    elem_t in_r1c2;
    elem_t in_r2c0;
    elem_t in_r2c1;
    elem_t in_r2c2;
  } mat_in_t;

  typedef struct packed {
    elem_t out_r0c0;
    elem_t out_r0c1;
    elem_t out_r0c2;
    elem_t out_r1c0;
    elem_t out_r1c1;
    elem_t out_r1c2;
    elem_t out_r2c0;
    elem_t out_r2c1;
    elem_t out_r2c2;
    logic  singular;
    logic  saturated;
  } mat_out_t;

  // per-lane status from the divider to the top level
  typedef struct packed {
    logic clip;
    logic zero;
  } lane_stat_t;

endpackage

// File: hdl/mi3_cofactor.sv
// ----------------------------------------------------------------------------
// mi3_cofactor
// Four-stage pipeline: cofactor products, cofactors, determinant products,
// determinant sum.
// ----------------------------------------------------------------------------
module mi3_cofactor import mi3_pkg::*; (
  input  logic    clk,
  input  logic    en,
  input  mat_in_t mat,
  output cof_t    cof [9],
  output det_t    det
);

  localparam int PW  = 2 * ELEM_W;
  localparam int DPW = ELEM_W + COF_W;

  // stage 1: cofactor products
  logic signed [PW-1:0] p [18];
  elem_t a1, b1, c1;

  always_ff @(posedge clk) begin
    if (en) begin
      p[0]  <= mat.in_r1c1 * mat.in_r2c2;  p[1]  <= mat.in_r1c2 * mat.in_r2c1;
      p[2]  <= mat.in_r0c2 * mat.in_r2c1;  p[3]  <= mat.in_r0c1 * mat.in_r2c2;
      p[4]  <= mat.in_r0c1 * mat.in_r1c2;  p[5]  <= mat.in_r0c2 * mat.in_r1c1;
      p[6]  <= mat.in_r1c2 * mat.in_r2c0;  p[7]  <= mat.in_r1c0 * mat.in_r2c2;
      p[8]  <= mat.in_r0c0 * mat.in_r2c2;  p[9]  <= mat.in_r0c2 * mat.in_r2c0;
      p[10] <= mat.in_r0c2 * mat.in_r1c0;  p[11] <= mat.in_r0c0 * mat.in_r1c2;
      p[12] <= mat.in_r1c0 * mat.in_r2c1;  p[13] <= mat.in_r1c1 * mat.in_r2c0;
      p[14] <= mat.in_r0c1 * mat.in_r2c0;  p[15] <= mat.in_r0c0 * mat.in_r2c1;
      p[16] <= mat.in_r0c0 * mat.in_r1c1;  p[17] <= mat.in_r0c1 * mat.in_r1c0;
      a1 <= mat.in_r0c0;
      b1 <= mat.in_r0c1;
      c1 <= mat.in_r0c2;
    end
  end

  // stage 2: cofactor differences
  cof_t  c2 [9];
  elem_t a2, b2, c2e;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        c2[k] <= COF_W'(p[2*k]) - COF_W'(p[2*k+1]);
      end
      a2  <= a1;
      b2  <= b1;
      c2e <= c1;
    end
  end

  // stage 3: first-row expansion products
  logic signed [DPW-1:0] dp [3];
  cof_t c3 [9];

  always_ff @(posedge clk) begin
    if (en) begin
      dp[0] <= a2 * c2[0];
      dp[1] <= b2 * c2[3];
      dp[2] <= c2e * c2[6];
      c3    <= c2;
    end
  end

  // stage 4: determinant sum
  always_ff @(posedge clk) begin
    if (en) begin
      det <= DET_W'(dp[0]) + DET_W'(dp[1]) + DET_W'(dp[2]);
      cof <= c3;
    end
  end

endmodule

// File: hdl/mi3_div_lane.sv
// ----------------------------------------------------------------------------
// mi3_div_lane
// Pipelined restoring divider: cofactor * 2^(2*FRAC_BITS) / det, truncated
// toward zero and clamped to the element range. One quotient bit per stage.
// ----------------------------------------------------------------------------
module mi3_div_lane import mi3_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       en,
  input  cof_t       cof,
  input  det_t       det,
  output elem_t      q,
  output lane_stat_t stat
);

  localparam int NW = COF_W + 2 * FRAC_BITS;   // scaled numerator magnitude
  localparam int XW = DET_W + QB;              // compare width
  localparam logic [QB-1:0] POS_LIM = QB'((1 << (ELEM_W - 1)) - 1);
  localparam logic [QB-1:0] NEG_LIM = QB'(1 << (ELEM_W - 1));

  // prep stage: magnitudes, sign, zero test
  logic [NW-1:0]    n0;
  logic [DET_W-1:0] d0;
  logic             neg0, zero0;

  always_ff @(posedge clk) begin
    if (en) begin
      n0    <= NW'(cof[COF_W-1] ? -cof : cof) << (2 * FRAC_BITS);
      d0    <= det[DET_W-1] ? -det : det;
      neg0  <= cof[COF_W-1] ^ det[DET_W-1];
      zero0 <= (det == '0);
    end
  end

  // step pipeline; index 0 holds the range check result
  logic [NW-1:0]    rem  [QB+1];
  logic [QB-1:0]    quo  [QB+1];
  logic [DET_W-1:0] dv   [QB+1];
  logic             sneg [QB+1];
  logic             szer [QB+1];
  logic             ssat [QB+1];

  // range check: quotient would need more than QB bits
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= n0;
      quo[0]  <= '0;
      dv[0]   <= d0;
      sneg[0] <= neg0;
      szer[0] <= zero0;
      ssat[0] <= XW'(n0) >= (XW'(d0) << QB);
    end
  end

  for (genvar s = 0; s < QB; s++) begin : g_step
    localparam int K = QB - 1 - s;
    logic [XW-1:0] trial;
    logic          take;
    assign trial = XW'(dv[s]) << K;
    assign take  = XW'(rem[s]) >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1]  <= take ? rem[s] - NW'(trial) : rem[s];
        quo[s+1]  <= quo[s] | (QB'(take) << K);
        dv[s+1]   <= dv[s];
        sneg[s+1] <= sneg[s];
        szer[s+1] <= szer[s];
        ssat[s+1] <= ssat[s];
      end
    end
  end

  // sign, clamp and singular override
  logic [QB-1:0] qf;
  logic          over;
  assign qf   = quo[QB];
  assign over = ssat[QB] || (sneg[QB] ? (qf > NEG_LIM) : (qf > POS_LIM));

  always_ff @(posedge clk) begin
    if (en) begin
      stat.zero <= szer[QB];
      if (szer[QB]) begin
        q         <= '0;
        stat.clip <= 1'b0;
      end else if (sneg[QB]) begin
        q         <= over ? -ELEM_W'(NEG_LIM) : -ELEM_W'(qf);
        stat.clip <= over;
      end else begin
        q         <= over ? ELEM_W'(POS_LIM) : ELEM_W'(qf);
        stat.clip <= over;
      end
    end
  end

endmodule

// File: hdl/matrix_inverse_3x3.sv
// ----------------------------------------------------------------------------
// matrix_inverse_3x3
// Inverse of a signed fixed-point 3x3 matrix by adjugate and determinant.
// ----------------------------------------------------------------------------
// Usage:
//   src channel: one 3x3 matrix request (row-major Q8.8) per src_valid cycle
//     with src_stall low. dst channel: the inverse, with singular set (and all
//     elements zero) for a zero determinant, saturated set if any element
//     was clamped to the 16-bit range.
//   Pipeline: the cofactor stages form cofactors and determinant; the
//     divider resolves one quotient bit per stage (17 bits) plus prep,
//     range check and clamp stages.
//   Throughput: one request per cycle while the pipeline is not held; nine divider lanes run in parallel.
//   Stall: the whole pipeline holds while a result waits with dst_stall
//     high; src_stall then follows. Nothing is lost or repeated.
//   Reset: clears all valid bits; no request is in flight afterwards.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3 import mi3_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     src_valid,
  output logic     src_stall,
  input  mat_in_t  src_data,
  output logic     dst_valid,
  input  logic     dst_stall,
  output mat_out_t dst_data
);

  localparam int LAT = COF_LAT + DIV_LAT;

  logic [LAT-1:0] vld;
  logic           en;

  // global advance: hold only when a finished result is not taken
  assign en        = !(vld[LAT-1] && dst_stall);
  assign src_stall = !en;
  assign dst_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], src_valid};
    end
  end

  // cofactors and determinant
  cof_t cof [9];
  det_t det;

  mi3_cofactor u_cof (
    .clk (clk),
    .en  (en),
    .mat (src_data),
    .cof (cof),
    .det (det)
  );

  // one divider lane per element
  elem_t      q    [9];
  lane_stat_t stat [9];

  for (genvar k = 0; k < 9; k++) begin : g_lane
    mi3_div_lane #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk  (clk),
      .en   (en),
      .cof  (cof[k]),
      .det  (det),
      .q    (q[k]),
      .stat (stat[k])
    );
  end

  // result assembly
  always_comb begin
    dst_data.out_r0c0  = q[0];
    dst_data.out_r0c1  = q[1];
    dst_data.out_r0c2  = q[2];
    dst_data.out_r1c0  = q[3];
    dst_data.out_r1c1  = q[4];
    dst_data.out_r1c2  = q[5];
    dst_data.out_r2c0  = q[6];
    dst_data.out_r2c1  = q[7];
    dst_data.out_r2c2  = q[8];
    dst_data.singular  = stat[0].zero;
    dst_data.saturated = 1'b0;
    for (int k = 0; k < 9; k++) begin
      dst_data.saturated = dst_data.saturated | stat[k].clip;
    end
  end

`ifndef SYNTHESIS
  a_sing_zero: assert property (@(posedge clk) disable iff (rst)
    dst_valid && dst_data.singular |->
      dst_data.out_r0c0 == '0 && dst_data.out_r1c1 == '0 && dst_data.out_r2c2 == '0)
    else $error("singular result with nonzero diagonal");
  a_sing_nosat: assert property (@(posedge clk) disable iff (rst)
    dst_valid && dst_data.singular |-> !dst_data.saturated)
    else $error("singular result flagged saturated");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    dst_valid && dst_stall |=> dst_valid && $stable(dst_data))
    else $error("stalled result changed");
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !dst_valid)
    else $error("result valid right after reset");
`endif

endmodule

// File: tb/sv/matrix_inverse_3x3_tb.sv
// ----------------------------------------------------------------------------
// matrix_inverse_3x3_tb
// Drives 3x3 Q8.8 matrices into the inverse block, with bursty requests,
// patterned output stalls, one long output hold-off and one drain pause, and
// checks every result against a typed row or in-bench adjugate/det predictor.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3_tb;
  import mi3_pkg::*;

  localparam int N_RANDOM    = 476;
  localparam int WDOG_LIMIT  = 5000;
  localparam int TAIL_CYCLES = 40;
  localparam int N_DIRECTED  = 14;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     src_valid = 1'b0;
  logic     src_stall;
  mat_in_t  src_data = '0;
  logic     dst_valid;
  logic     dst_stall = 1'b0;
  mat_out_t dst_data;

  mat_out_t inverse_q[$];
  int       mismatches = 0;
  int       idle_cycles = 0;
  bit       hold_long = 1'b0;
  bit       stim_done = 1'b0;

  // directed stimulus, with typed result where obvious
  mat_in_t  dir_mat [N_DIRECTED];
  mat_out_t dir_res [N_DIRECTED];
  bit       dir_has [N_DIRECTED];

  matrix_inverse_3x3 DUT (
    .clk(clk), .rst(rst),
    .src_valid(src_valid), .src_stall(src_stall), .src_data(src_data),
    .dst_valid(dst_valid), .dst_stall(dst_stall), .dst_data(dst_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // one inverse element: cof * 2^16 / det, truncated, clamped
  function automatic elem_t div_clamp(longint cof, longint det, ref bit clip);
    bit      neg;
    longint  q;
    neg = (cof < 0) != (det < 0);
    q = ((cof < 0 ? -cof : cof) <<< (2 * FRAC_BITS_DEF)) / (det < 0 ? -det : det);
    if (!neg && q > 32767) begin
      q = 32767;
      clip = 1'b1;
    end else if (neg && q > 32768) begin
      q = 32768;
      clip = 1'b1;
    end
    return neg ? elem_t'(-q) : elem_t'(q);
  endfunction

  function automatic mat_out_t predict_inverse(mat_in_t m);
    longint   a, b, c, d, e, f, g, h, i, det;
    longint   adj [9];
    mat_out_t r;
    bit       clip;
    elem_t    o [9];
    a = m.in_r0c0; b = m.in_r0c1; c = m.in_r0c2;
    d = m.in_r1c0; e = m.in_r1c1; f = m.in_r1c2;
    g = m.in_r2c0; h = m.in_r2c1; i = m.in_r2c2;
    adj[0] = e*i - f*h; adj[1] = c*h - b*i; adj[2] = b*f - c*e;
    adj[3] = f*g - d*i; adj[4] = a*i - c*g; adj[5] = c*d - a*f;
    adj[6] = d*h - e*g; adj[7] = b*g - a*h; adj[8] = a*e - b*d;
    det = a*adj[0] + b*adj[3] + c*adj[6];
    r = '0;
    clip = 1'b0;
    if (det == 0) begin
      r.singular = 1'b1;
      return r;
    end
    for (int k = 0; k < 9; k++) o[k] = div_clamp(adj[k], det, clip);
    r = {o[0], o[1], o[2], o[3], o[4], o[5], o[6], o[7], o[8], 1'b0, clip};
    return r;
  endfunction

  function automatic mat_in_t diag(elem_t x, elem_t y, elem_t z);
    return {x, 16'sd0, 16'sd0, 16'sd0, y, 16'sd0, 16'sd0, 16'sd0, z};
  endfunction

  function automatic mat_in_t random_matrix();
    mat_in_t m;
    int      kind;
    elem_t   el [9];
    kind = $urandom_range(0, 9);
    for (int k = 0; k < 9; k++) begin
      case (kind)
        0, 1, 2, 3: el[k] = elem_t'($urandom);
        4, 5:       el[k] = elem_t'($signed($urandom_range(0, 1024)) - 512);
        6:          el[k] = elem_t'($signed($urandom_range(0, 8)) - 4);
        7:          el[k] = ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
        default:    el[k] = elem_t'($signed($urandom_range(0, 64)) - 32);
      endcase
    end
    m = {el[0], el[1], el[2], el[3], el[4], el[5], el[6], el[7], el[8]};
    // occasionally force a singular matrix: row 2 copies row 0
    if (kind == 9) m.in_r2c0 = m.in_r0c0;
    if (kind == 9) m.in_r2c1 = m.in_r0c1;
    if (kind == 9) m.in_r2c2 = m.in_r0c2;
    return m;
  endfunction

  // offer one request with its expected result and hold it until accepted
  task automatic offer_request(mat_in_t m, mat_out_t exp_r);
    src_valid <= 1'b1;
    src_data  <= m;
    inverse_q.push_back(exp_r);
    @(posedge clk);
    while (src_stall) @(posedge clk);
  endtask

  task automatic send_request(mat_in_t m);
    offer_request(m, predict_inverse(m));
  endtask

  task automatic idle_cycles_n(int n);
    src_valid <= 1'b0;
    src_data  <= random_matrix();
    repeat (n) @(posedge clk);
  endtask

  initial begin
    mat_out_t zero_sing;
    zero_sing = '0;
    zero_sing.singular = 1'b1;
    for (int k = 0; k < N_DIRECTED; k++) dir_has[k] = 1'b0;
    // all zeros: singular
    dir_mat[0] = '0;                         dir_res[0] = zero_sing; dir_has[0] = 1;
    // identity in Q8.8
    dir_mat[1] = diag(16'sh0100, 16'sh0100, 16'sh0100);
    dir_res[1] = {16'sh0100, 16'sd0, 16'sd0, 16'sd0, 16'sh0100, 16'sd0,
                  16'sd0, 16'sd0, 16'sh0100, 1'b0, 1'b0};
    dir_has[1] = 1;
    // tiny diagonal: inverse clips high
    dir_mat[2] = diag(16'sd1, 16'sd1, 16'sd1);
    dir_res[2] = {16'sh7fff, 16'sd0, 16'sd0, 16'sd0, 16'sh7fff, 16'sd0,
                  16'sd0, 16'sd0, 16'sh7fff, 1'b0, 1'b1};
    dir_has[2] = 1;
    // negative tiny diagonal: clips low
    dir_mat[3] = diag(-16'sd1, -16'sd1, -16'sd1);
    dir_res[3] = {16'sh8000, 16'sd0, 16'sd0, 16'sd0, 16'sh8000, 16'sd0,
                  16'sd0, 16'sd0, 16'sh8000, 1'b0, 1'b1};
    dir_has[3] = 1;
    // all equal elements: singular
    dir_mat[4] = {9{16'sh7fff}};             dir_res[4] = zero_sing; dir_has[4] = 1;
    dir_mat[5] = {9{16'sh8000}};             dir_res[5] = zero_sing; dir_has[5] = 1;
    dir_mat[6] = diag(16'sh7fff, 16'sh7fff, 16'sh7fff);
    dir_mat[7] = diag(16'sh8000, 16'sh8000, 16'sh8000);
    dir_mat[8] = diag(16'sh8000, 16'sh7fff, 16'sh8000);
    dir_mat[9] = diag(16'sh0200, -16'sh0080, 16'sh0400);
    dir_mat[10] = {16'sh0100, 16'sh0200, 16'sh0300, 16'sh0000, 16'sh0100,
                   16'sh0400, 16'sh0500, 16'sh0600, 16'sh0000};
    dir_mat[11] = {16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
                   16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000};
    dir_mat[12] = {16'shffff, 16'sh0001, 16'sh0000, 16'sh0000, 16'shffff,
                   16'sh0001, 16'sh0001, 16'sh0000, 16'shffff};
    dir_mat[13] = {16'sh5555, 16'shaaaa, 16'sh0f0f, 16'shf0f0, 16'sh3333,
                   16'shcccc, 16'sh00ff, 16'shff00, 16'sh1234};

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table: typed rows check against the table, others the predictor
    for (int k = 0; k < N_DIRECTED; k++) begin
      if (dir_has[k]) offer_request(dir_mat[k], dir_res[k]);
      else send_request(dir_mat[k]);
    end
    idle_cycles_n(1);

    // long output hold-off while requests keep coming
    hold_long <= 1'b1;
    for (int k = 0; k < 60; k++) send_request(random_matrix());
    hold_long <= 1'b0;

    // pause until drained
    src_valid <= 1'b0;
    while (inverse_q.size() != 0) @(posedge clk);

    // random bursts
    for (int n = 0; n < N_RANDOM; ) begin
      int burst;
      burst = $urandom_range(1, 20);
      for (int k = 0; k < burst && n < N_RANDOM; k++, n++)
        send_request(random_matrix());
      if ($urandom_range(0, 3) != 0) idle_cycles_n($urandom_range(1, 8));
    end
    src_valid <= 1'b0;
    stim_done <= 1'b1;
  end

  // receiver stall pattern, plus the long hold-off
  initial begin
    int phase;
    phase = 0;
    forever begin
      @(posedge clk);
      if (hold_long) begin
        dst_stall <= 1'b1;
        repeat (100) @(posedge clk);
        dst_stall <= 1'b0;
        wait (!hold_long);
      end else begin
        phase = (phase + 1) % 64;
        if (phase < 16) dst_stall <= 1'b0;
        else dst_stall <= ($urandom_range(0, 2) == 0);
      end
    end
  end

  // result checking
  always @(posedge clk) begin
    mat_out_t exp_r;
    if (!rst && dst_valid && !dst_stall) begin
      if (inverse_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", dst_data);
      end else begin
        exp_r = inverse_q.pop_front();
        if (dst_data !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h got %h", exp_r, dst_data);
        end
      end
    end
  end

  // watchdog and end of run
  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if ((src_valid && !src_stall) || (dst_valid && !dst_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("matrix_inverse_3x3_tb failed");
        $finish;
      end
      if (stim_done && inverse_q.size() == 0) begin
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && inverse_q.size() == 0)
          $display("matrix_inverse_3x3_tb passed");
        else
          $display("matrix_inverse_3x3_tb failed");
        $finish;
      end
    end
  end

endmodule

// File: filelist.f
hdl/mi3_pkg.sv
hdl/mi3_cofactor.sv
hdl/mi3_div_lane.sv
hdl/matrix_inverse_3x3.sv
tb/sv/matrix_inverse_3x3_tb.sv
